// ===== rtl/core/sarsa_lambda_trace_update_defines.svh =====
// Assertion macros shared by the SARSA(lambda) trace update RTL.
`ifndef SARSA_LAMBDA_TRACE_UPDATE_DEFINES_SVH
`define SARSA_LAMBDA_TRACE_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slt_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the SARSA(lambda) trace update modules.
package slt_pkg;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [23:0] TRACE_MAX = 24'hFFFFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_ADDR,
        ST_FAIL,
        ST_RD_NXT,
        ST_RD_CUR,
        ST_DELTA,
        ST_GL,
        ST_CHK,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_FIN
    } slt_state_t;

    typedef enum logic [1:0] {
        CFG_LEARN_RATE  = 2'd0,
        CFG_DISCOUNT    = 2'd1,
        CFG_TRACE_DECAY = 2'd2,
        CFG_MIN_TRACE   = 2'd3
    } slt_cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_GAMMA_Q,
        MUL_GAMMA_LAMBDA,
        MUL_ALPHA_TRACE,
        MUL_TRACE_GL,
        MUL_AE_DELTA
    } slt_mul_sel_t;

    typedef struct packed {
        slt_mul_sel_t sel;
        logic [16:0]  alpha;
        logic [16:0]  gamma;
        logic [16:0]  lambda;
        logic [23:0]  trace;
        logic [24:0]  ae;
        logic [32:0]  gl;
        logic [31:0]  delta;
        logic [31:0]  qval;
    } slt_mul_ops_t;

endpackage

// ===== rtl/core/slt_mul.sv =====
`timescale 1ns / 1ps
// Shared multiplier with operand selection and a registered product.
module slt_mul (
    input  logic                 clk,
    input  slt_pkg::slt_mul_ops_t ops,
    output logic signed [59:0]   prod
);

    logic signed [25:0] op_a;
    logic signed [33:0] op_b;
    logic signed [59:0] prod_next;
    logic signed [59:0] prod_reg;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ops.sel)
            slt_pkg::MUL_GAMMA_Q:
            begin
                op_a = $signed({9'd0, ops.gamma});
                op_b = $signed({{2{ops.qval[31]}}, ops.qval});
            end
            slt_pkg::MUL_GAMMA_LAMBDA:
            begin
                op_a = $signed({9'd0, ops.gamma});
                op_b = $signed({17'd0, ops.lambda});
            end
            slt_pkg::MUL_ALPHA_TRACE:
            begin
                op_a = $signed({9'd0, ops.alpha});
                op_b = $signed({10'd0, ops.trace});
            end
            slt_pkg::MUL_TRACE_GL:
            begin
                op_a = $signed({2'd0, ops.trace});
                op_b = $signed({1'b0, ops.gl});
            end
            slt_pkg::MUL_AE_DELTA:
            begin
                op_a = $signed({1'b0, ops.ae});
                op_b = $signed({{2{ops.delta[31]}}, ops.delta});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/sarsa_lambda_trace_update.sv =====
`timescale 1ns / 1ps
// Top level of the SARSA(lambda) action-value learner with eligibility traces.
// This block holds one action value (signed Q15.16), one trace (unsigned Q8.16) and
// one active mark for every state-action pair, pair (s, a) at entry s * NUM_ACTIONS + a.
// After reset a clearing pass over all NUM_STATES * NUM_ACTIONS entries zeroes
// all three tables; in_ready stays low until it is done, while configuration writes
// are taken at any time. One input beat is worked on at a time. A fail beat reduces
// its indexes and writes the reward as the value of the current pair. A learn beat
// reduces its indexes, reads Q(next) and Q(cur), forms delta, adds one to the trace
// and sets the mark of the current pair, then scans every table entry: the scan reads
// one entry per cycle from the tables, which have one read port and one write port
// each, and each pair that stays active holds the scan while it works on the one
// shared multiplier (alpha * trace, trace * gamma * lambda, and the value step). The
// result beat sits in an output register, so the next input beat can be taken while
// it waits for out_ready.
module sarsa_lambda_trace_update #(
    parameter int NUM_STATES  = 256,
    parameter int NUM_ACTIONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  state_index,
    input  logic [2:0]  action_index,
    input  logic signed [31:0] reward,
    input  logic [7:0]  next_state_index,
    input  logic [2:0]  next_action_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] td_error,
    output logic [11:0] active_count
);

`include "sarsa_lambda_trace_update_defines.svh"

    localparam int PAIRS = NUM_STATES * NUM_ACTIONS;
    localparam int AW    = $clog2(PAIRS);
    localparam logic [AW-1:0] LAST = AW'(PAIRS - 1);

    function automatic logic [31:0] sat32(input logic signed [41:0] x);
        if (x > 42'sd2147483647)
            return 32'h7FFFFFFF;
        else if (x < -42'sd2147483648)
            return 32'h80000000;
        else
            return x[31:0];
    endfunction

    // Tables. Each has one write port and one registered read port.
    logic [31:0] q_mem [PAIRS];
    logic [23:0] t_mem [PAIRS];
    logic        m_mem [PAIRS];

    logic [31:0] q_rd_reg;
    logic [23:0] t_rd_reg;
    logic        m_rd_reg;

    logic [AW-1:0] rd_addr;
    logic          q_we, t_we, m_we;
    logic [AW-1:0] q_waddr, t_waddr, m_waddr;
    logic [31:0]   q_wdata;
    logic [23:0]   t_wdata;
    logic          m_wdata;

    // Sequencer and datapath registers.
    slt_pkg::slt_state_t state_reg, state_next;
    logic        op_reg, op_next;
    logic signed [31:0] reward_reg, reward_next;
    logic [7:0]  s_red_reg, s_red_next, ns_red_reg, ns_red_next;
    logic [2:0]  a_red_reg, a_red_next, na_red_reg, na_red_next;
    logic [AW-1:0] cur_reg, cur_next, nxt_reg, nxt_next, base_reg, base_next;
    logic [AW:0]   end_reg, end_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0] delta_reg, delta_next;
    logic [32:0] gl_reg, gl_next;
    logic [24:0] ae_reg, ae_next;
    logic [23:0] tr_reg, tr_next;
    logic [11:0] total_reg, total_next;

    logic [16:0] learn_rate_reg, discount_reg, trace_decay_reg;
    logic [23:0] min_trace_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] td_error_reg, td_error_next;
    logic [11:0] active_count_reg, active_count_next;

    // Shared multiplier.
    slt_pkg::slt_mul_ops_t mul_ops;
    logic signed [59:0]    prod;

    slt_mul u_mul (
        .clk  (clk),
        .ops  (mul_ops),
        .prod (prod)
    );

    // Rates above one act as one.
    logic [16:0] alpha_eff, gamma_eff, lambda_eff;
    assign alpha_eff  = (learn_rate_reg  > slt_pkg::ONE_Q16) ? slt_pkg::ONE_Q16 : learn_rate_reg;
    assign gamma_eff  = (discount_reg    > slt_pkg::ONE_Q16) ? slt_pkg::ONE_Q16 : discount_reg;
    assign lambda_eff = (trace_decay_reg > slt_pkg::ONE_Q16) ? slt_pkg::ONE_Q16 : trace_decay_reg;

    // Index reduction compares.
    logic s_big, a_big, ns_big, na_big;
    assign s_big  = ({24'd0, s_red_reg}  >= 32'(NUM_STATES));
    assign ns_big = ({24'd0, ns_red_reg} >= 32'(NUM_STATES));
    assign a_big  = ({29'd0, a_red_reg}  >= 32'(NUM_ACTIONS));
    assign na_big = ({29'd0, na_red_reg} >= 32'(NUM_ACTIONS));

    logic [AW-1:0] cur_base, nxt_base;
    assign cur_base = AW'(AW'(s_red_reg) * AW'(NUM_ACTIONS));
    assign nxt_base = AW'(AW'(ns_red_reg) * AW'(NUM_ACTIONS));

    // Delta: reward*2^16 + gamma*Q(next) - Q(cur)*2^16, rounded half up and saturated.
    logic signed [51:0] acc, acc_rnd;
    logic signed [35:0] delta_sh;
    assign acc = $signed({{4{reward_reg[31]}}, reward_reg, 16'd0}) + prod[51:0]
               - $signed({{4{q_rd_reg[31]}}, q_rd_reg, 16'd0});
    assign acc_rnd  = acc + 52'sd32768;
    assign delta_sh = acc_rnd[51:16];

    // Trace plus one, saturated.
    logic [24:0] t_inc;
    assign t_inc = {1'b0, t_rd_reg} + 25'd65536;

    // Scan arithmetic.
    logic        same_state;
    logic [23:0] trace_eff;
    logic signed [59:0] prod_rnd15, prod_rnd31;
    logic signed [41:0] q_sum;
    assign same_state = ({1'b0, idx_reg} >= {1'b0, base_reg}) && ({1'b0, idx_reg} < end_reg)
                     && (idx_reg != cur_reg);
    assign trace_eff  = same_state ? 24'd0 : t_rd_reg;
    assign prod_rnd15 = prod + 60'sd32768;
    assign prod_rnd31 = prod + 60'sd2147483648;
    assign q_sum = $signed({{10{q_rd_reg[31]}}, q_rd_reg}) + prod_rnd15[57:16];

    // Table ports.
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        q_rd_reg <= q_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            t_mem[t_waddr] <= t_wdata;
        t_rd_reg <= t_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
            m_mem[m_waddr] <= m_wdata;
        m_rd_reg <= m_mem[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg  <= 17'd6554;
            discount_reg    <= 17'd62259;
            trace_decay_reg <= 17'd52429;
            min_trace_reg   <= 24'd66;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slt_pkg::CFG_LEARN_RATE:  learn_rate_reg  <= cfg_data[16:0];
                slt_pkg::CFG_DISCOUNT:    discount_reg    <= cfg_data[16:0];
                slt_pkg::CFG_TRACE_DECAY: trace_decay_reg <= cfg_data[16:0];
                slt_pkg::CFG_MIN_TRACE:   min_trace_reg   <= cfg_data;
                default:                  min_trace_reg   <= min_trace_reg;
            endcase
        end
    end

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= slt_pkg::ST_CLEAR;
            op_reg           <= 1'b0;
            reward_reg       <= '0;
            s_red_reg        <= '0;
            a_red_reg        <= '0;
            ns_red_reg       <= '0;
            na_red_reg       <= '0;
            cur_reg          <= '0;
            nxt_reg          <= '0;
            base_reg         <= '0;
            end_reg          <= '0;
            idx_reg          <= '0;
            delta_reg        <= '0;
            gl_reg           <= '0;
            ae_reg           <= '0;
            tr_reg           <= '0;
            total_reg        <= '0;
            out_valid_reg    <= 1'b0;
            td_error_reg     <= '0;
            active_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            reward_reg       <= reward_next;
            s_red_reg        <= s_red_next;
            a_red_reg        <= a_red_next;
            ns_red_reg       <= ns_red_next;
            na_red_reg       <= na_red_next;
            cur_reg          <= cur_next;
            nxt_reg          <= nxt_next;
            base_reg         <= base_next;
            end_reg          <= end_next;
            idx_reg          <= idx_next;
            delta_reg        <= delta_next;
            gl_reg           <= gl_next;
            ae_reg           <= ae_next;
            tr_reg           <= tr_next;
            total_reg        <= total_next;
            out_valid_reg    <= out_valid_next;
            td_error_reg     <= td_error_next;
            active_count_reg <= active_count_next;
        end
    end

    // Sequencer: next state, table ports and multiplier operands.
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        reward_next       = reward_reg;
        s_red_next        = s_red_reg;
        a_red_next        = a_red_reg;
        ns_red_next       = ns_red_reg;
        na_red_next       = na_red_reg;
        cur_next          = cur_reg;
        nxt_next          = nxt_reg;
        base_next         = base_reg;
        end_next          = end_reg;
        idx_next          = idx_reg;
        delta_next        = delta_reg;
        gl_next           = gl_reg;
        ae_next           = ae_reg;
        tr_next           = tr_reg;
        total_next        = total_reg;
        td_error_next     = td_error_reg;
        active_count_next = active_count_reg;
        out_valid_next    = out_valid_reg && !out_ready;

        rd_addr = idx_reg;
        q_we    = 1'b0;
        q_waddr = idx_reg;
        q_wdata = '0;
        t_we    = 1'b0;
        t_waddr = idx_reg;
        t_wdata = '0;
        m_we    = 1'b0;
        m_waddr = idx_reg;
        m_wdata = 1'b0;

        mul_ops        = '0;
        mul_ops.sel    = slt_pkg::MUL_GAMMA_Q;
        mul_ops.alpha  = alpha_eff;
        mul_ops.gamma  = gamma_eff;
        mul_ops.lambda = lambda_eff;
        mul_ops.trace  = tr_reg;
        mul_ops.ae     = ae_reg;
        mul_ops.gl     = gl_reg;
        mul_ops.delta  = delta_reg;
        mul_ops.qval   = q_rd_reg;

        case (state_reg)
            slt_pkg::ST_CLEAR:
            begin
                q_we = 1'b1;
                t_we = 1'b1;
                m_we = 1'b1;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = slt_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            slt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    reward_next = reward;
                    s_red_next  = state_index;
                    a_red_next  = action_index;
                    ns_red_next = next_state_index;
                    na_red_next = next_action_index;
                    state_next  = slt_pkg::ST_MOD;
                end
            end
            slt_pkg::ST_MOD:
            begin
                if (s_big)
                    s_red_next = s_red_reg - 8'(NUM_STATES);
                if (ns_big)
                    ns_red_next = ns_red_reg - 8'(NUM_STATES);
                if (a_big)
                    a_red_next = a_red_reg - 3'(NUM_ACTIONS);
                if (na_big)
                    na_red_next = na_red_reg - 3'(NUM_ACTIONS);
                if (!s_big && !ns_big && !a_big && !na_big)
                    state_next = slt_pkg::ST_ADDR;
            end
            slt_pkg::ST_ADDR:
            begin
                base_next  = cur_base;
                end_next   = {1'b0, cur_base} + (AW+1)'(NUM_ACTIONS);
                cur_next   = cur_base + AW'(a_red_reg);
                nxt_next   = nxt_base + AW'(na_red_reg);
                state_next = op_reg ? slt_pkg::ST_FAIL : slt_pkg::ST_RD_NXT;
            end
            slt_pkg::ST_FAIL:
            begin
                q_we       = 1'b1;
                q_waddr    = cur_reg;
                q_wdata    = reward_reg;
                delta_next = '0;
                state_next = slt_pkg::ST_FIN;
            end
            slt_pkg::ST_RD_NXT:
            begin
                rd_addr    = nxt_reg;
                state_next = slt_pkg::ST_RD_CUR;
            end
            slt_pkg::ST_RD_CUR:
            begin
                // Q(next) is on the read port now; Q(cur) arrives next cycle.
                rd_addr     = cur_reg;
                mul_ops.sel = slt_pkg::MUL_GAMMA_Q;
                state_next  = slt_pkg::ST_DELTA;
            end
            slt_pkg::ST_DELTA:
            begin
                rd_addr     = cur_reg;
                delta_next  = sat32($signed({{6{delta_sh[35]}}, delta_sh}));
                mul_ops.sel = slt_pkg::MUL_GAMMA_LAMBDA;
                t_we        = 1'b1;
                t_waddr     = cur_reg;
                t_wdata     = t_inc[24] ? slt_pkg::TRACE_MAX : t_inc[23:0];
                m_we        = 1'b1;
                m_waddr     = cur_reg;
                m_wdata     = 1'b1;
                if (!m_rd_reg)
                    total_next = total_reg + 1'b1;
                state_next  = slt_pkg::ST_GL;
            end
            slt_pkg::ST_GL:
            begin
                gl_next    = prod[32:0];
                rd_addr    = '0;
                idx_next   = '0;
                state_next = slt_pkg::ST_CHK;
            end
            slt_pkg::ST_CHK:
            begin
                if (m_rd_reg && (trace_eff >= min_trace_reg))
                begin
                    mul_ops.sel   = slt_pkg::MUL_ALPHA_TRACE;
                    mul_ops.trace = trace_eff;
                    tr_next       = trace_eff;
                    state_next    = slt_pkg::ST_M1;
                end
                else
                begin
                    if (m_rd_reg)
                    begin
                        // Trace below the threshold: drop the mark, write trace_eff.
                        m_we       = 1'b1;
                        m_wdata    = 1'b0;
                        t_we       = 1'b1;
                        t_wdata    = trace_eff;
                        total_next = total_reg - 1'b1;
                    end
                    if (idx_reg == LAST)
                    begin
                        state_next = slt_pkg::ST_FIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            slt_pkg::ST_M1:
            begin
                ae_next     = prod_rnd15[40:16];
                mul_ops.sel = slt_pkg::MUL_TRACE_GL;
                state_next  = slt_pkg::ST_M2;
            end
            slt_pkg::ST_M2:
            begin
                t_we        = 1'b1;
                t_wdata     = prod_rnd31[55:32];
                mul_ops.sel = slt_pkg::MUL_AE_DELTA;
                state_next  = slt_pkg::ST_M3;
            end
            slt_pkg::ST_M3:
            begin
                q_we    = 1'b1;
                q_wdata = sat32(q_sum);
                if (idx_reg == LAST)
                begin
                    state_next = slt_pkg::ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                    state_next = slt_pkg::ST_CHK;
                end
            end
            slt_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    td_error_next     = delta_reg;
                    active_count_next = total_reg;
                    state_next        = slt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slt_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready     = (state_reg == slt_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign td_error     = td_error_reg;
    assign active_count = active_count_reg;

    `SLT_ASSERT_NEXT(a_one_beat_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready,
        "input taken again right after a beat")
    `SLT_ASSERT_IMPL(a_no_input_while_clearing, clk, rst_n,
        state_reg == slt_pkg::ST_CLEAR, !in_ready, "input ready during clearing pass")
    `SLT_ASSERT_NEXT(a_finish_delivers, clk, rst_n,
        state_reg == slt_pkg::ST_FIN && !out_valid_reg, out_valid,
        "finished beat did not reach the output register")

endmodule
